[rtl/core/ffea_pkg.sv]
package ffea_pkg;

  localparam int unsigned MaxExtentsDefault  = 16;
  localparam int unsigned ReservedDefault    = 2;
  localparam logic [15:0] DiskBlocksReset    = 16'd1024;
  // one request ends after at most this many moves
  localparam int unsigned MaxMoves           = 16;

  typedef enum logic [2:0] {
    KIND_MOVED     = 3'd0,
    KIND_ALLOCATED = 3'd1,
    KIND_FREED     = 3'd2,
    KIND_NO_SPACE  = 3'd3,
    KIND_TAG_EXISTS = 3'd4,
    KIND_NOT_FOUND = 3'd5,
    KIND_FULL      = 3'd6
  } kind_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] start;
    logic [15:0] length;
  } entry_t;

endpackage

[rtl/core/ffea_table.sv]
module ffea_table #(
  parameter int unsigned MAX_EXTENTS = ffea_pkg::MaxExtentsDefault,
  localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1
) (
  input  logic             clk_i,
  input  logic [IW-1:0]    rd_idx_i,
  output ffea_pkg::entry_t rd_entry_o,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_idx_i,
  input  ffea_pkg::entry_t wr_entry_i
);

  ffea_pkg::entry_t mem_q [MAX_EXTENTS];

  // entries beyond the fill count are never read, so no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
  end

  assign rd_entry_o = mem_q[rd_idx_i];

endmodule

[rtl/core/first_fit_extent_allocator_unit.sv]
// First-fit extent allocator: keeps up to MAX_EXTENTS extents sorted by start block and
// serves one allocate or free request at a time; s_axis_tready is high only while idle.
// A request walks the table one entry per cycle through a single subtract/compare unit:
// the tag scan comes first, then a free shifts the table down, while an allocate searches
// the gaps and then shifts the table up. When no gap fits, each compaction move is a
// search for the first open gap, the output transfer of the move and a fresh gap search,
// with at most 16 moves per request.
module first_fit_extent_allocator_unit #(
  parameter int unsigned MAX_EXTENTS     = ffea_pkg::MaxExtentsDefault,
  parameter int unsigned RESERVED_BLOCKS = ffea_pkg::ReservedDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // disk_blocks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // file_tag[7:0], length_blocks[23:8]
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // kind, tag_out, old_start, new_start, length_out, zeros
  output logic        m_axis_tlast
);

  localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_EXTENTS);
  localparam logic [16:0] ResEnd = 17'(RESERVED_BLOCKS);
  localparam logic [4:0] MoveLimit = 5'(ffea_pkg::MaxMoves);

  typedef enum logic [2:0] {
    ST_IDLE, ST_TAG, ST_DEL, ST_GAP, ST_CMP, ST_INS, ST_OUT
  } state_e;

  state_e          state_q;
  logic [15:0]     disk_q;
  logic [15:0]     used_q;
  logic [CW-1:0]   cnt_q, i_q, j_q, slot_q;
  logic [16:0]     prev_q;
  logic [4:0]      moves_q;
  logic            op_q;
  logic [7:0]      tag_q;
  logic [15:0]     len_q;
  ffea_pkg::kind_e res_kind_q;
  logic [7:0]      res_tag_q;
  logic [15:0]     res_old_q, res_new_q, res_len_q;
  logic            res_last_q;

  ffea_pkg::entry_t rd_entry, wr_entry;
  logic             wr_en;
  logic [CW-1:0]    rd_pos, wr_pos;

  // shared subtract/compare unit
  logic        at_end;
  logic [16:0] cmp_x;
  logic [17:0] diff;
  logic        fits, gap_open;
  logic [16:0] cur_end;
  logic [15:0] avail;

  assign at_end   = (i_q == cnt_q);
  assign cmp_x    = at_end ? {1'b0, disk_q} : {1'b0, rd_entry.start};
  assign diff     = {1'b0, cmp_x} - {1'b0, prev_q};
  assign fits     = !diff[17] && (diff[16:0] >= {1'b0, len_q});
  assign gap_open = !diff[17] && (diff != 18'd0);
  assign cur_end  = {1'b0, rd_entry.start} + {1'b0, rd_entry.length};
  assign avail    = (disk_q > used_q) ? (disk_q - used_q) : 16'd0;

  always_comb begin
    rd_pos   = i_q;
    wr_en    = 1'b0;
    wr_pos   = i_q;
    wr_entry = rd_entry;
    unique case (state_q)
      ST_DEL: begin
        rd_pos = j_q + CW'(1);
        wr_pos = j_q;
        wr_en  = (j_q + CW'(1)) < cnt_q;
      end
      ST_CMP: begin
        wr_en          = !at_end && gap_open;
        wr_entry.start = prev_q[15:0];
      end
      ST_INS: begin
        rd_pos = j_q - CW'(1);
        wr_pos = j_q;
        wr_en  = 1'b1;
        if (j_q <= slot_q) begin
          wr_pos   = slot_q;
          wr_entry = '{tag: tag_q, start: prev_q[15:0], length: len_q};
        end
      end
      default: ;
    endcase
  end

  ffea_table #(.MAX_EXTENTS(MAX_EXTENTS)) u_table (
    .clk_i      (clk_i),
    .rd_idx_i   (rd_pos[IW-1:0]),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_pos[IW-1:0]),
    .wr_entry_i (wr_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      disk_q     <= ffea_pkg::DiskBlocksReset;
      used_q     <= 16'(RESERVED_BLOCKS);
      cnt_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      slot_q     <= '0;
      prev_q     <= ResEnd;
      moves_q    <= '0;
      op_q       <= 1'b0;
      tag_q      <= '0;
      len_q      <= '0;
      res_kind_q <= ffea_pkg::KIND_MOVED;
      res_tag_q  <= '0;
      res_old_q  <= '0;
      res_new_q  <= '0;
      res_len_q  <= '0;
      res_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        disk_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tuser;
            tag_q   <= s_axis_tdata[7:0];
            len_q   <= s_axis_tdata[23:8];
            i_q     <= '0;
            state_q <= ST_TAG;
          end
        end
        ST_TAG: begin
          if (at_end) begin
            if (op_q == ffea_pkg::OP_FREE) begin
              res_kind_q <= ffea_pkg::KIND_NOT_FOUND;
              res_tag_q  <= tag_q;
              res_old_q  <= '0;
              res_new_q  <= '0;
              res_len_q  <= '0;
              res_last_q <= 1'b1;
              state_q    <= ST_OUT;
            end else if (cnt_q >= MaxCnt) begin
              res_kind_q <= ffea_pkg::KIND_FULL;
              res_tag_q  <= tag_q;
              res_old_q  <= '0;
              res_new_q  <= '0;
              res_len_q  <= len_q;
              res_last_q <= 1'b1;
              state_q    <= ST_OUT;
            end else if (len_q == 16'd0 || len_q > avail) begin
              res_kind_q <= ffea_pkg::KIND_NO_SPACE;
              res_tag_q  <= tag_q;
              res_old_q  <= '0;
              res_new_q  <= '0;
              res_len_q  <= len_q;
              res_last_q <= 1'b1;
              state_q    <= ST_OUT;
            end else begin
              i_q     <= '0;
              prev_q  <= ResEnd;
              moves_q <= '0;
              state_q <= ST_GAP;
            end
          end else if (rd_entry.tag == tag_q) begin
            res_tag_q  <= tag_q;
            res_new_q  <= '0;
            res_last_q <= 1'b1;
            if (op_q == ffea_pkg::OP_FREE) begin
              res_kind_q <= ffea_pkg::KIND_FREED;
              res_old_q  <= rd_entry.start;
              res_len_q  <= rd_entry.length;
              j_q        <= i_q;
              state_q    <= ST_DEL;
            end else begin
              res_kind_q <= ffea_pkg::KIND_TAG_EXISTS;
              res_old_q  <= '0;
              res_len_q  <= len_q;
              state_q    <= ST_OUT;
            end
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        ST_DEL: begin
          if ((j_q + CW'(1)) < cnt_q) begin
            j_q <= j_q + CW'(1);
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            used_q  <= (used_q >= res_len_q) ? (used_q - res_len_q) : 16'd0;
            state_q <= ST_OUT;
          end
        end
        ST_GAP: begin
          if (fits) begin
            slot_q  <= i_q;
            j_q     <= cnt_q;
            state_q <= ST_INS;
          end else if (at_end) begin
            if (moves_q < MoveLimit) begin
              i_q     <= '0;
              prev_q  <= ResEnd;
              state_q <= ST_CMP;
            end else begin
              res_kind_q <= ffea_pkg::KIND_NO_SPACE;
              res_tag_q  <= tag_q;
              res_old_q  <= '0;
              res_new_q  <= '0;
              res_len_q  <= len_q;
              res_last_q <= 1'b1;
              state_q    <= ST_OUT;
            end
          end else begin
            prev_q <= cur_end;
            i_q    <= i_q + CW'(1);
          end
        end
        ST_CMP: begin
          if (at_end) begin
            res_kind_q <= ffea_pkg::KIND_NO_SPACE;
            res_tag_q  <= tag_q;
            res_old_q  <= '0;
            res_new_q  <= '0;
            res_len_q  <= len_q;
            res_last_q <= 1'b1;
            state_q    <= ST_OUT;
          end else if (gap_open) begin
            res_kind_q <= ffea_pkg::KIND_MOVED;
            res_tag_q  <= rd_entry.tag;
            res_old_q  <= rd_entry.start;
            res_new_q  <= prev_q[15:0];
            res_len_q  <= rd_entry.length;
            res_last_q <= 1'b0;
            moves_q    <= moves_q + 5'd1;
            state_q    <= ST_OUT;
          end else begin
            prev_q <= cur_end;
            i_q    <= i_q + CW'(1);
          end
        end
        ST_INS: begin
          if (j_q > slot_q) begin
            j_q <= j_q - CW'(1);
          end else begin
            cnt_q      <= cnt_q + CW'(1);
            used_q     <= used_q + len_q;
            res_kind_q <= ffea_pkg::KIND_ALLOCATED;
            res_tag_q  <= tag_q;
            res_old_q  <= '0;
            res_new_q  <= prev_q[15:0];
            res_len_q  <= len_q;
            res_last_q <= 1'b1;
            state_q    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (res_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              // search again from the start after a move
              i_q     <= '0;
              prev_q  <= ResEnd;
              state_q <= ST_GAP;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tlast  = res_last_q;
  assign m_axis_tdata  = {5'd0, res_len_q, res_new_q, res_old_q, res_tag_q, res_kind_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt) else $error("extent count above table size");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input and output open together");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after accepted transfer");

  a_move_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    moves_q <= MoveLimit) else $error("too many moves");

endmodule

[tb/first_fit_extent_allocator_unit_tb.sv]
`timescale 1ns / 100ps

module first_fit_extent_allocator_unit_tb;

  localparam int NumSlots    = ffea_pkg::MaxExtentsDefault;
  localparam int Reserved    = ffea_pkg::ReservedDefault;
  localparam int StallLimit  = 20000;
  localparam int SettleTicks = 80;

  typedef struct packed {
    ffea_pkg::kind_e kind;
    logic [7:0]      tag;
    logic [15:0]     old_start;
    logic [15:0]     new_start;
    logic [15:0]     len;
    logic            last;
  } extent_result_t;

  typedef struct {
    logic           op;
    logic [7:0]     tag;
    logic [15:0]    len;
    bit             typed;
    extent_result_t res;
  } request_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // file_tag[7:0], length_blocks[23:8]
  logic        s_axis_tuser = 1'b0; // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // kind, tag_out, old_start, new_start, length_out, zeros
  logic        m_axis_tlast;

  first_fit_extent_allocator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow copy of the extent table
  logic [15:0] ext_start [NumSlots];
  logic [15:0] ext_len   [NumSlots];
  logic [7:0]  ext_tag   [NumSlots];
  int          ext_count;
  int          used_blocks;
  int          disk_blocks;

  extent_result_t pending_q[$];
  request_row_t   directed_q[$];
  int             mismatches = 0;
  int             send_idle = 0;
  int             recv_idle = 0;
  int             stall_cycles = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int extent_end(input int i);
    return int'(ext_start[i]) + int'(ext_len[i]);
  endfunction

  function automatic int tag_slot(input logic [7:0] tag);
    for (int i = 0; i < ext_count; i++) begin
      if (ext_tag[i] == tag) return i;
    end
    return -1;
  endfunction

  function automatic bit first_fit(input int len, output int pos, output int slot);
    if (ext_count == 0) begin
      pos = Reserved;
      slot = 0;
      return (Reserved + len <= disk_blocks);
    end
    if (ext_start[0] >= Reserved && int'(ext_start[0]) - Reserved >= len) begin
      pos = Reserved;
      slot = 0;
      return 1'b1;
    end
    for (int i = 1; i < ext_count; i++) begin
      if (ext_start[i] >= extent_end(i - 1) && ext_start[i] - extent_end(i - 1) >= len) begin
        pos = extent_end(i - 1);
        slot = i;
        return 1'b1;
      end
    end
    pos = extent_end(ext_count - 1);
    slot = ext_count;
    return (disk_blocks >= pos && disk_blocks - pos >= len);
  endfunction

  function automatic bit close_gap(output int idx, output int pos);
    if (ext_count == 0) return 1'b0;
    if (ext_start[0] > Reserved) begin
      idx = 0;
      pos = Reserved;
      return 1'b1;
    end
    for (int i = 1; i < ext_count; i++) begin
      if (extent_end(i - 1) < ext_start[i]) begin
        idx = i;
        pos = extent_end(i - 1);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_result(input ffea_pkg::kind_e kind, input logic [7:0] tag,
                                      input int olds, input int news, input int len,
                                      input logic last);
    extent_result_t r;
    r = '{kind, tag, olds[15:0], news[15:0], len[15:0], last};
    pending_q = {pending_q, r};
  endfunction

  function automatic void add_row(input request_row_t r);
    directed_q = {directed_q, r};
  endfunction

  function automatic void predict_request(input logic op, input logic [7:0] tag, input int len);
    int f, pos, slot, idx, moves, avail, old;
    f = tag_slot(tag);
    if (op == ffea_pkg::OP_FREE) begin
      if (f < 0) begin
        push_result(ffea_pkg::KIND_NOT_FOUND, tag, 0, 0, 0, 1'b1);
        return;
      end
      push_result(ffea_pkg::KIND_FREED, tag, ext_start[f], 0, ext_len[f], 1'b1);
      used_blocks = (used_blocks >= ext_len[f]) ? used_blocks - ext_len[f] : 0;
      for (int i = f; i + 1 < ext_count; i++) begin
        ext_start[i] = ext_start[i + 1];
        ext_len[i] = ext_len[i + 1];
        ext_tag[i] = ext_tag[i + 1];
      end
      ext_count--;
      return;
    end
    if (f >= 0) begin
      push_result(ffea_pkg::KIND_TAG_EXISTS, tag, 0, 0, len, 1'b1);
      return;
    end
    if (ext_count >= NumSlots) begin
      push_result(ffea_pkg::KIND_FULL, tag, 0, 0, len, 1'b1);
      return;
    end
    avail = (disk_blocks > used_blocks) ? disk_blocks - used_blocks : 0;
    if (len == 0 || len > avail) begin
      push_result(ffea_pkg::KIND_NO_SPACE, tag, 0, 0, len, 1'b1);
      return;
    end
    moves = 0;
    forever begin
      if (first_fit(len, pos, slot)) begin
        for (int i = ext_count; i > slot; i--) begin
          ext_start[i] = ext_start[i - 1];
          ext_len[i] = ext_len[i - 1];
          ext_tag[i] = ext_tag[i - 1];
        end
        ext_start[slot] = pos[15:0];
        ext_len[slot] = len[15:0];
        ext_tag[slot] = tag;
        ext_count++;
        used_blocks = (used_blocks + len) & 16'hFFFF;
        push_result(ffea_pkg::KIND_ALLOCATED, tag, 0, pos, len, 1'b1);
        return;
      end
      if (moves < ffea_pkg::MaxMoves && close_gap(idx, pos)) begin
        old = ext_start[idx];
        ext_start[idx] = pos[15:0];
        push_result(ffea_pkg::KIND_MOVED, ext_tag[idx], old, pos, ext_len[idx], 1'b0);
        moves++;
      end else begin
        push_result(ffea_pkg::KIND_NO_SPACE, tag, 0, 0, len, 1'b1);
        return;
      end
    end
  endfunction

  task automatic send_request(input logic op, input logic [7:0] tag, input logic [15:0] len);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {len, tag};
    // ready is settled mid-cycle, so the next rising edge is the accepting one
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    predict_request(op, tag, len);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic set_disk(input logic [15:0] blocks);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= blocks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    disk_blocks = blocks;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    extent_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        report("result with nothing pending");
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[2:0] != want.kind)
          report($sformatf("kind %0d, want %0d", m_axis_tdata[2:0], want.kind));
        if (m_axis_tdata[10:3] != want.tag)
          report($sformatf("tag %0d, want %0d", m_axis_tdata[10:3], want.tag));
        if (m_axis_tdata[26:11] != want.old_start)
          report($sformatf("old_start %0d, want %0d", m_axis_tdata[26:11], want.old_start));
        if (m_axis_tdata[42:27] != want.new_start)
          report($sformatf("new_start %0d, want %0d", m_axis_tdata[42:27], want.new_start));
        if (m_axis_tdata[58:43] != want.len)
          report($sformatf("length %0d, want %0d", m_axis_tdata[58:43], want.len));
        if (m_axis_tdata[63:59] != '0)
          report("padding bits not zero");
        if (m_axis_tlast != want.last)
          report($sformatf("tlast %0b, want %0b", m_axis_tlast, want.last));
      end
    end
  end

  // watchdog on transfers in either direction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    request_row_t row;
    logic [15:0]  disk_plan [6];
    logic         op;
    logic [7:0]   tag;
    logic [15:0]  len;
    int           pick, len_cap;

    ext_count = 0;
    used_blocks = Reserved;
    disk_blocks = ffea_pkg::DiskBlocksReset;
    for (int i = 0; i < NumSlots; i++) begin
      ext_start[i] = '0;
      ext_len[i] = '0;
      ext_tag[i] = '0;
    end

    add_row('{ffea_pkg::OP_FREE, 8'd7, 16'd0, 1'b1,
              '{ffea_pkg::KIND_NOT_FOUND, 8'd7, 16'd0, 16'd0, 16'd0, 1'b1}});
    add_row('{ffea_pkg::OP_ALLOC, 8'd1, 16'd0, 1'b1,
              '{ffea_pkg::KIND_NO_SPACE, 8'd1, 16'd0, 16'd0, 16'd0, 1'b1}});
    add_row('{ffea_pkg::OP_ALLOC, 8'd1, 16'hFFFF, 1'b1,
              '{ffea_pkg::KIND_NO_SPACE, 8'd1, 16'd0, 16'd0, 16'hFFFF, 1'b1}});
    add_row('{ffea_pkg::OP_ALLOC, 8'd1, 16'd10, 1'b1,
              '{ffea_pkg::KIND_ALLOCATED, 8'd1, 16'd0, 16'd2, 16'd10, 1'b1}});
    add_row('{ffea_pkg::OP_ALLOC, 8'd1, 16'd3, 1'b1,
              '{ffea_pkg::KIND_TAG_EXISTS, 8'd1, 16'd0, 16'd0, 16'd3, 1'b1}});
    add_row('{ffea_pkg::OP_ALLOC, 8'd255, 16'd20, 1'b0, '0});
    add_row('{ffea_pkg::OP_ALLOC, 8'd0, 16'd30, 1'b0, '0});
    add_row('{ffea_pkg::OP_FREE, 8'd1, 16'hFFFF, 1'b1,
              '{ffea_pkg::KIND_FREED, 8'd1, 16'd2, 16'd0, 16'd10, 1'b1}});
    add_row('{ffea_pkg::OP_FREE, 8'd0, 16'd0, 1'b0, '0});
    // only fits after the remaining extent slides down to the reserved area
    add_row('{ffea_pkg::OP_ALLOC, 8'd2, 16'd1000, 1'b0, '0});
    add_row('{ffea_pkg::OP_FREE, 8'd2, 16'd0, 1'b0, '0});
    // fill the table, then one more
    for (int i = 0; i < 15; i++) add_row('{ffea_pkg::OP_ALLOC, 8'(10 + i), 16'd1, 1'b0, '0});
    add_row('{ffea_pkg::OP_ALLOC, 8'd30, 16'd1, 1'b1,
              '{ffea_pkg::KIND_FULL, 8'd30, 16'd0, 16'd0, 16'd1, 1'b1}});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      row = directed_q[i];
      send_request(row.op, row.tag, row.len);
      if (row.typed) pending_q[$] = row.res;
    end
    drain();

    disk_plan = '{16'd200, 16'd3, 16'hFFFF, 16'd120, 16'($urandom_range(3, 65535)), 16'd300};
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle = 26;
          recv_idle = 58;
        end
        1: begin
          send_idle = 58;
          recv_idle = 26;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      set_disk(disk_plan[phase]);
      len_cap = (disk_blocks / 5 > 1) ? disk_blocks / 5 : 1;
      for (int n = 0; n < 32; n++) begin
        op = ($urandom_range(99) < 40) ? ffea_pkg::OP_FREE : ffea_pkg::OP_ALLOC;
        tag = ($urandom_range(99) < 85) ? 8'($urandom_range(0, 23)) : 8'($urandom_range(0, 255));
        pick = $urandom_range(99);
        if (op == ffea_pkg::OP_FREE || pick < 10) len = 16'($urandom_range(0, 65535));
        else if (pick < 14) len = 16'd0;
        else len = 16'($urandom_range(1, len_cap));
        send_request(op, tag, len);
      end
      drain();
    end

    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
